// ----- rtl/scld_pkg.sv -----
// Package for the serial command line decoder: command codes, character
// constants and the small classification helpers. No dependencies.

package scld_pkg;

   typedef logic [2:0] cmd_type;

   localparam cmd_type CMD_HELLO    = 3'd0;
   localparam cmd_type CMD_LIST     = 3'd1;
   localparam cmd_type CMD_GET      = 3'd2;
   localparam cmd_type CMD_BAD_DATE = 3'd3;
   localparam cmd_type CMD_BYE      = 3'd4;
   localparam cmd_type CMD_UNKNOWN  = 3'd5;

   localparam int unsigned POS_W = 5;
   localparam int unsigned TIMEOUT_W = 16;
   localparam int unsigned DATE_W = 32;

   localparam logic [POS_W-1:0] POS_MAX          = 5'd31;
   localparam logic [POS_W-1:0] DATE_MIN_POS     = 5'd4;
   localparam logic [POS_W-1:0] DATE_START_LIMIT = 5'd21;
   localparam logic [POS_W-1:0] DATE_LEN         = 5'd10;
   localparam logic [POS_W-1:0] DATE_DASH1       = 5'd4;
   localparam logic [POS_W-1:0] DATE_DASH2       = 5'd7;
   localparam logic [POS_W-1:0] LIST_LAST        = 5'd3;
   localparam logic [POS_W-1:0] BYE_LAST         = 5'd2;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;

   // Keywords, left aligned in five character slots.
   localparam logic [39:0] KW_HELLO = "HELLO";
   localparam logic [39:0] KW_LIST  = {"LIST", 8'h00};
   localparam logic [39:0] KW_GET   = {"GET ", 8'h00};
   localparam logic [39:0] KW_BYE   = {"BYE", 16'h0000};

   // Flag bits: HELLO, LIST, GET, BYE.
   localparam int unsigned FLAG_HELLO = 0;
   localparam int unsigned FLAG_LIST  = 1;
   localparam int unsigned FLAG_GET   = 2;
   localparam int unsigned FLAG_BYE   = 3;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // True when character c at content position p breaks the keyword.
   function automatic logic kw_miss(input logic [39:0] kw, input logic [2:0] len,
                                    input logic [POS_W-1:0] p, input logic [7:0] c);
      logic miss;
      miss = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if ((p == POS_W'(i)) && (3'(i) < len) && (kw[39-8*i -: 8] != c)) begin
            miss = 1'b1;
         end
      end
      return miss;
   endfunction

endpackage

// ----- rtl/serial_command_line_decoder_core.sv -----
// Serial command line decoder top level: input register, per-line match
// state and result register in one module. Depends on scld_pkg.
//
// Channel   Direction  Contents
// req_*     in         func (0 byte, 1 ms tick), rx_byte
// rsp_*     out        command, date_bcd (one transaction per non-empty line)
// csr_*     in         line_timeout_ms write, no read-back
//
// One transaction accepted per cycle while req_stall is low. The path is
// the input register, then the line state update and result register.
// A line feed transaction produces its result from the state left by the
// bytes before it, so no line buffer is kept.
// reset is synchronous, active high; it restores the timeout to 100 and
// clears the line state. A stalled result holds the input register,
// which stalls the request side only while both stages are full.

module serial_command_line_decoder_core
   import scld_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_command,
   output logic [DATE_W-1:0]    rsp_date_bcd,
   input  logic                 csr_wr_en,
   input  logic [TIMEOUT_W-1:0] csr_wr_data
);

   // Configuration
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_func_ff, s1_func_in;
   logic [7:0] s1_byte_ff, s1_byte_in;

   // Line state
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic                 raw_nonempty_ff, raw_nonempty_in;
   logic                 started_ff, started_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     last_ff, last_in;
   logic [3:0]           flags_ff, flags_in;
   logic [POS_W-1:0]     date_start_ff, date_start_in;
   logic                 date_ok_ff, date_ok_in;
   logic [DATE_W-1:0]    digits_ff, digits_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   cmd_type           rsp_cmd_ff, rsp_cmd_in;
   logic [DATE_W-1:0] rsp_date_ff, rsp_date_in;

   // Working signals
   logic                 s1_adv;
   logic                 ws;
   logic                 clear_line;
   logic [TIMEOUT_W-1:0] elapsed_inc;
   logic [POS_W-1:0]     date_off;
   logic                 date_take;
   cmd_type              cls_cmd;
   logic [DATE_W-1:0]    cls_date;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign ws        = is_ws(s1_byte_ff);

   // Classification of the line held in the state registers (used at LF).
   always_comb begin
      cls_cmd  = CMD_UNKNOWN;
      cls_date = '0;
      if (started_ff) begin
         if (flags_ff[FLAG_HELLO] && (last_ff >= DATE_MIN_POS)) begin
            cls_cmd = CMD_HELLO;
         end else if (flags_ff[FLAG_LIST] && (last_ff == LIST_LAST)) begin
            cls_cmd = CMD_LIST;
         end else if (flags_ff[FLAG_GET] && (last_ff >= DATE_MIN_POS)) begin
            if ((date_start_ff != '0) && date_ok_ff && (last_ff >= date_start_ff) &&
                ((last_ff - date_start_ff) == (DATE_LEN - 5'd1))) begin
               cls_cmd  = CMD_GET;
               cls_date = digits_ff;
            end else begin
               cls_cmd = CMD_BAD_DATE;
            end
         end else if (flags_ff[FLAG_BYE] && (last_ff == BYE_LAST)) begin
            cls_cmd = CMD_BYE;
         end
      end
   end

   always_comb begin
      timeout_in      = timeout_ff;
      s1_valid_in     = s1_valid_ff;
      s1_func_in      = s1_func_ff;
      s1_byte_in      = s1_byte_ff;
      elapsed_in      = elapsed_ff;
      raw_nonempty_in = raw_nonempty_ff;
      started_in      = started_ff;
      pos_in          = pos_ff;
      last_in         = last_ff;
      flags_in        = flags_ff;
      date_start_in   = date_start_ff;
      date_ok_in      = date_ok_ff;
      digits_in       = digits_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_cmd_in      = rsp_cmd_ff;
      rsp_date_in     = rsp_date_ff;
      clear_line      = 1'b0;
      elapsed_inc     = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;
      date_off        = (date_start_ff == '0) ? '0 : pos_ff - date_start_ff;
      date_take       = 1'b0;

      if (csr_wr_en) begin
         timeout_in = csr_wr_data;
      end

      // Input register refills whenever it empties or moves on.
      if (s1_adv || !s1_valid_ff) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_func_in = req_func;
            s1_byte_in = req_rx_byte;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_adv) begin
         if (s1_func_ff) begin
            // Tick: a timeout of zero behaves as one.
            if (elapsed_inc >= timeout_ff) begin
               clear_line = 1'b1;
               elapsed_in = '0;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end else if (s1_byte_ff == CHAR_CR) begin
            // ignored
         end else if (s1_byte_ff == CHAR_LF) begin
            if (raw_nonempty_ff) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = cls_cmd;
               rsp_date_in  = cls_date;
            end
            clear_line = 1'b1;
            elapsed_in = '0;
         end else if (!started_ff && ws) begin
            raw_nonempty_in = 1'b1;  // leading whitespace
         end else begin
            raw_nonempty_in = 1'b1;
            started_in      = 1'b1;
            if (kw_miss(KW_HELLO, 3'd5, pos_ff, s1_byte_ff)) flags_in[FLAG_HELLO] = 1'b0;
            if (kw_miss(KW_LIST, 3'd4, pos_ff, s1_byte_ff))  flags_in[FLAG_LIST]  = 1'b0;
            if (kw_miss(KW_GET, 3'd4, pos_ff, s1_byte_ff))   flags_in[FLAG_GET]   = 1'b0;
            if (kw_miss(KW_BYE, 3'd3, pos_ff, s1_byte_ff))   flags_in[FLAG_BYE]   = 1'b0;
            if (!ws) begin
               last_in = pos_ff;
            end

            // Date tracking starts at the first non-space past "GET ".
            if (pos_ff >= DATE_MIN_POS) begin
               if (date_start_ff == '0) begin
                  if (!ws) begin
                     date_start_in = pos_ff;
                     if (pos_ff > DATE_START_LIMIT) begin
                        date_ok_in = 1'b0;
                     end
                     date_take = 1'b1;
                  end
               end else if (date_off < DATE_LEN) begin
                  date_take = 1'b1;
               end else if (!ws) begin
                  date_ok_in = 1'b0;
               end
            end

            if (date_take) begin
               if ((date_off == DATE_DASH1) || (date_off == DATE_DASH2)) begin
                  if (s1_byte_ff != CHAR_DASH) begin
                     date_ok_in = 1'b0;
                  end
               end else if (is_digit(s1_byte_ff)) begin
                  digits_in = {digits_ff[DATE_W-5:0], s1_byte_ff[3:0]};
               end else begin
                  date_ok_in = 1'b0;
               end
            end

            pos_in = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : POS_MAX;
         end
      end

      if (clear_line) begin
         raw_nonempty_in = 1'b0;
         started_in      = 1'b0;
         pos_in          = '0;
         last_in         = '0;
         flags_in        = '1;
         date_start_in   = '0;
         date_ok_in      = 1'b1;
         digits_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         s1_valid_ff     <= 1'b0;
         elapsed_ff      <= '0;
         raw_nonempty_ff <= 1'b0;
         started_ff      <= 1'b0;
         pos_ff          <= '0;
         last_ff         <= '0;
         flags_ff        <= '1;
         date_start_ff   <= '0;
         date_ok_ff      <= 1'b1;
         digits_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         timeout_ff      <= timeout_in;
         s1_valid_ff     <= s1_valid_in;
         elapsed_ff      <= elapsed_in;
         raw_nonempty_ff <= raw_nonempty_in;
         started_ff      <= started_in;
         pos_ff          <= pos_in;
         last_ff         <= last_in;
         flags_ff        <= flags_in;
         date_start_ff   <= date_start_in;
         date_ok_ff      <= date_ok_in;
         digits_ff       <= digits_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      s1_func_ff  <= s1_func_in;
      s1_byte_ff  <= s1_byte_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_date_ff <= rsp_date_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_command  = rsp_cmd_ff;
   assign rsp_date_bcd = rsp_date_ff;

   // A date is only reported with a valid GET.
   a_date_only_get: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_cmd_ff != CMD_GET)) |-> (rsp_date_ff == '0))
      else $error("date_bcd nonzero for non-GET command");

   // A new result only follows a line feed leaving the input register.
   a_result_from_lf: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(s1_adv && !s1_func_ff && (s1_byte_ff == CHAR_LF)))
      else $error("result produced without a line feed");

   // Last non-space position never runs ahead of the content position;
   // last reaches the top only if a non-space byte arrives once the position saturates.
   a_last_behind_pos: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (last_ff <= pos_ff))
      else $error("last non-space position ahead of content position");

endmodule
